FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the clique search RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on the rising clock edge, masked while reset is asserted.
`define DGMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check on the rising clock edge, also during reset.
`define DGMC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/core/dgmc_pkg.sv
// Package for the disk graph maximum clique block: payload types, FSM states,
// and the command/status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package dgmc_pkg;

  // One disk request on the input channel
  typedef struct packed {
    logic [9:0] centre_x;
    logic [9:0] centre_y;
    logic [7:0] radius;
    logic       is_last;
  } disk_req_t;

  // One clique member on the output channel
  typedef struct packed {
    logic [3:0] member_index;
    logic [4:0] clique_size;
    logic [6:0] edge_total;
    logic       overflowed;
    logic       last_member;
  } clique_res_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_SQ,
    ST_CMP,
    ST_SEARCH,
    ST_EMIT
  } dgmc_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_en;
    logic build_init;
    logic pair_read;
    logic pair_square;
    logic pair_cmp;
    logic search_init;
    logic search_step;
    logic emit_step;
  } dgmc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_last_fire;
    logic pairs_done;
    logic search_last;
    logic emit_done;
  } dgmc_stat_t;

endpackage

FILE: rtl/core/dgmc_chan_if.sv
// Valid/ready channel interface carrying one request payload of type T.
// Used by the top level ports; no package dependency.
`timescale 1ns / 1ps

interface dgmc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/disk_graph_max_clique.sv
// Usage notes for disk_graph_max_clique (maximum clique of a disk graph).
// Input channel disk_in: one request per disk (centre_x, centre_y, radius in
// tenths, is_last). Requests are taken one per cycle while the block loads;
// up to MAX_DISKS are stored, further ones are dropped and flagged.
// The request with is_last set closes the set and starts the search; the
// input stays not ready until the clique has been handed out.
// Processing of a set of n disks: the adjacency build walks each disk pair
// through memory read, square and compare; the clique checker then tests
// the 2^n - 1 nonempty subsets, one subset per cycle; then the member scan
// steps over the disk indices up to the last member (halted when the receiver
// stalls).
// Output channel clique_out: one request per clique member, ascending index,
// with clique size, edge count, overflow flag and last_member on the final one.
// An output register holds each result until taken; a stall halts the scan,
// and the last result may wait there while the next set loads.
// Reset clears the disk count, flags, best clique and the output valid;
// no clearing pass is needed.
// Depends on dgmc_pkg, dgmc_chan_if, dgmc_ctrl and dgmc_datapath.
`timescale 1ns / 1ps

module disk_graph_max_clique
  import dgmc_pkg::*;
#(
  parameter int MAX_DISKS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dgmc_chan_if.sink    disk_in,
  dgmc_chan_if.source  clique_out
);

  dgmc_cmd_t  cmd;
  dgmc_stat_t stat;

  // Input is open only while loading
  assign disk_in.ready = cmd.load_en;

  dgmc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  dgmc_datapath #(
    .MAX_DISKS (MAX_DISKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (disk_in.valid),
    .in_req_i    (disk_in.payload),
    .out_valid_o (clique_out.valid),
    .out_res_o   (clique_out.payload),
    .out_ready_i (clique_out.ready),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

FILE: rtl/core/dgmc_ctrl.sv
// Controller FSM for the clique search: load, pairwise adjacency build,
// subset search and member emission. Depends on dgmc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dgmc_ctrl
  import dgmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dgmc_stat_t stat_i,
  output dgmc_cmd_t  cmd_o
);

  dgmc_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.load_en = 1'b1;
        if (stat_i.in_last_fire) begin
          cmd_o.build_init = 1'b1;
          state_d          = ST_RD;
        end
      end
      ST_RD: begin
        if (stat_i.pairs_done) begin
          cmd_o.search_init = 1'b1;
          state_d           = ST_SEARCH;
        end else begin
          cmd_o.pair_read = 1'b1;
          state_d         = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.pair_square = 1'b1;
        state_d           = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.pair_cmp = 1'b1;
        state_d        = ST_RD;
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (stat_i.search_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_step = 1'b1;
        if (stat_i.emit_done) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // A set closes with its last request: no new request until the search is over
  `DGMC_ASSERT(a_busy_after_last, clk_i, rst_ni, stat_i.in_last_fire |=> !cmd_o.load_en, "input open right after last disk")
  // The final member hands the block back to loading
  `DGMC_ASSERT(a_load_after_emit, clk_i, rst_ni, (cmd_o.emit_step && stat_i.emit_done) |=> cmd_o.load_en, "not loading after final member")

endmodule

FILE: rtl/core/dgmc_datapath.sv
// Datapath of the clique search: disk store, distance test, adjacency rows,
// edge count, subset checker, best clique and output register.
// Depends on dgmc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dgmc_datapath
  import dgmc_pkg::*;
#(
  parameter int MAX_DISKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  disk_req_t   in_req_i,
  output logic        out_valid_o,
  output clique_res_t out_res_o,
  input  logic        out_ready_i,
  input  dgmc_cmd_t   cmd_i,
  output dgmc_stat_t  stat_o
);

  localparam int IW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int CW = $clog2(MAX_DISKS + 1);
  localparam int PW = CW + 1;
  localparam int SW = MAX_DISKS + 1;
  localparam logic [4:0] ResultCap = 5'd16;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] r;
  } disk_rec_t;

  // Storage
  disk_rec_t              mem_q [MAX_DISKS];
  disk_rec_t              rd_a_q, rd_b_q;
  logic [MAX_DISKS-1:0]   adj_q [MAX_DISKS];

  // Control registers
  logic [CW-1:0]          count_q, count_d;
  logic                   overflow_q, overflow_d;
  logic [PW-1:0]          pi_q, pi_d, pj_q, pj_d;
  logic [6:0]             edges_q, edges_d;
  logic [SW-1:0]          subset_q, subset_d;
  logic [MAX_DISKS-1:0]   best_mask_q, best_mask_d;
  logic [CW-1:0]          best_size_q, best_size_d;
  logic [IW-1:0]          ei_q, ei_d;
  logic [4:0]             emitted_q, emitted_d;
  logic                   out_valid_q, out_valid_d;
  clique_res_t            out_q;

  // Pair arithmetic
  logic [9:0]             dx, dy;
  logic [8:0]             rs;
  logic [19:0]            dx2_q, dy2_q;
  logic [17:0]            rs2_q;
  logic [20:0]            dist_sq;
  logic                   touch;

  // Search and emission helpers
  logic                   in_fire, count_full;
  logic [PW-1:0]          n_ext;
  logic [SW-1:0]          full_mask;
  logic [MAX_DISKS-1:0]   sub_m, bad;
  logic                   clique_ok;
  logic [CW-1:0]          pc;
  logic [CW+4:0]          size_ext;
  logic [4:0]             total;
  logic [IW+3:0]          ei_ext;
  logic                   slot_free, emit_hit, last_now;

  assign in_fire    = in_valid_i && cmd_i.load_en;
  assign count_full = (count_q == CW'(MAX_DISKS));
  assign n_ext      = PW'(count_q);

  // Disk store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (in_fire && !count_full) begin
      mem_q[count_q[IW-1:0]] <= '{x: in_req_i.centre_x, y: in_req_i.centre_y,
                                  r: in_req_i.radius};
    end
    if (cmd_i.pair_read) begin
      rd_a_q <= mem_q[pi_q[IW-1:0]];
      rd_b_q <= mem_q[pj_q[IW-1:0]];
    end
  end

  // Distance terms, squared into registers
  always_comb begin
    dx = (rd_a_q.x > rd_b_q.x) ? rd_a_q.x - rd_b_q.x : rd_b_q.x - rd_a_q.x;
    dy = (rd_a_q.y > rd_b_q.y) ? rd_a_q.y - rd_b_q.y : rd_b_q.y - rd_a_q.y;
    rs = {1'b0, rd_a_q.r} + {1'b0, rd_b_q.r};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pair_square) begin
      dx2_q <= 20'(dx) * 20'(dx);
      dy2_q <= 20'(dy) * 20'(dy);
      rs2_q <= 18'(rs) * 18'(rs);
    end
  end

  assign dist_sq = 21'(dx2_q) + 21'(dy2_q);
  assign touch   = (dist_sq <= 21'(rs2_q));

  // Adjacency rows: cleared per set, written symmetrically per pair
  always_ff @(posedge clk_i) begin
    if (cmd_i.build_init) begin
      for (int k = 0; k < MAX_DISKS; k++) adj_q[k] <= '0;
    end else if (cmd_i.pair_cmp && touch) begin
      adj_q[pi_q[IW-1:0]][pj_q[IW-1:0]] <= 1'b1;
      adj_q[pj_q[IW-1:0]][pi_q[IW-1:0]] <= 1'b1;
    end
  end

  // Clique test of the current subset, one row check per disk
  assign sub_m = subset_q[MAX_DISKS-1:0];
  always_comb begin
    for (int k = 0; k < MAX_DISKS; k++) begin
      bad[k] = sub_m[k] && ((sub_m & ~(MAX_DISKS'(1) << k) & ~adj_q[k]) != '0);
    end
  end
  assign clique_ok = ~|bad;
  assign pc        = CW'($countones(sub_m));
  assign full_mask = (SW'(1) << count_q) - SW'(1);

  // Emission bookkeeping
  assign size_ext  = {5'b0, best_size_q};
  assign total     = (size_ext > (CW + 5)'(ResultCap)) ? ResultCap : size_ext[4:0];
  assign ei_ext    = {4'b0, ei_q};
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit_hit  = cmd_i.emit_step && slot_free && best_mask_q[ei_q];
  assign last_now  = ((emitted_q + 5'd1) == total);

  // Next-state logic of the control registers
  always_comb begin
    count_d     = count_q;
    overflow_d  = overflow_q;
    pi_d        = pi_q;
    pj_d        = pj_q;
    edges_d     = edges_q;
    subset_d    = subset_q;
    best_mask_d = best_mask_q;
    best_size_d = best_size_q;
    ei_d        = ei_q;
    emitted_d   = emitted_q;
    out_valid_d = out_valid_q;

    // accept a disk or note the drop
    if (in_fire) begin
      if (count_full) overflow_d = 1'b1;
      else            count_d    = count_q + CW'(1);
    end

    // pair walk over i < j < n
    if (cmd_i.build_init) begin
      pi_d    = '0;
      pj_d    = PW'(1);
      edges_d = '0;
    end
    if (cmd_i.pair_cmp) begin
      if (touch) edges_d = edges_q + 7'd1;
      if ((pj_q + PW'(1)) == n_ext) begin
        pi_d = pi_q + PW'(1);
        pj_d = pi_q + PW'(2);
      end else begin
        pj_d = pj_q + PW'(1);
      end
    end

    // subset search, first strictly larger clique wins
    if (cmd_i.search_init) begin
      subset_d    = SW'(1);
      best_mask_d = '0;
      best_size_d = '0;
      ei_d        = '0;
      emitted_d   = '0;
    end
    if (cmd_i.search_step) begin
      if ((pc > best_size_q) && clique_ok) begin
        best_mask_d = sub_m;
        best_size_d = pc;
      end
      subset_d = subset_q + SW'(1);
    end

    // member scan into the output register
    if (out_ready_i) out_valid_d = 1'b0;
    if (emit_hit) begin
      out_valid_d = 1'b1;
      emitted_d   = emitted_q + 5'd1;
    end
    if (cmd_i.emit_step && slot_free) ei_d = ei_q + IW'(1);
    if (emit_hit && last_now) begin
      count_d    = '0;
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      overflow_q  <= 1'b0;
      pi_q        <= '0;
      pj_q        <= '0;
      edges_q     <= '0;
      subset_q    <= '0;
      best_mask_q <= '0;
      best_size_q <= '0;
      ei_q        <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      pi_q        <= pi_d;
      pj_q        <= pj_d;
      edges_q     <= edges_d;
      subset_q    <= subset_d;
      best_mask_q <= best_mask_d;
      best_size_q <= best_size_d;
      ei_q        <= ei_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (emit_hit) begin
      out_q.member_index <= ei_ext[3:0];
      out_q.clique_size  <= size_ext[4:0];
      out_q.edge_total   <= edges_q;
      out_q.overflowed   <= overflow_q;
      out_q.last_member  <= last_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Status to the controller
  assign stat_o.in_last_fire = in_fire && in_req_i.is_last;
  assign stat_o.pairs_done   = (pj_q >= n_ext);
  assign stat_o.search_last  = (subset_q == full_mask);
  assign stat_o.emit_done    = emit_hit && last_now;

  `DGMC_ASSERT_NR(a_count_range, clk_i,
                  count_q <= CW'(MAX_DISKS), "disk count beyond capacity")
  `DGMC_ASSERT(a_best_pop, clk_i, rst_ni,
               best_size_q == CW'($countones(best_mask_q)), "best size differs from best mask")
  `DGMC_ASSERT(a_set_cleared, clk_i, rst_ni,
               stat_o.emit_done |=> (count_q == '0 && !overflow_q),
               "set not cleared after final member")

endmodule
